>>> rtl/rrcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcb_pkg
// Shared widths, register indexes, pipeline types and the divide-by-255
// helper for the rounded-rectangle coverage blend.
// ----------------------------------------------------------------------------
package rrcb_pkg;

   // Coordinate and length widths
   localparam int COORD_BITS = 16;
   localparam int LEN_BITS   = COORD_BITS - 1;
   // clamped radius never exceeds half of a length
   localparam int RAD_BITS   = LEN_BITS - 1;
   // positions such as left + width need two more bits
   localparam int POS_BITS   = COORD_BITS + 2;
   localparam int SQ_BITS    = 2 * RAD_BITS;
   localparam int DIST_BITS  = SQ_BITS + 1;
   localparam int DEN_BITS   = RAD_BITS + 1;
   localparam int COV_BITS   = 8;
   localparam int NUM_BITS   = DEN_BITS + COV_BITS;
   localparam int DIV_STAGES = COV_BITS;

   localparam int PIX_BITS      = 32;
   localparam int REQ_DATA_BITS = 2 * COORD_BITS + PIX_BITS;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECT_LEFT     = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECT_TOP      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECT_WIDTH    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECT_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORNER_RADIUS = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FILL_COLOR    = 3'd5;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // One coverage-division stage: hit = pixel is drawn, full = no antialiasing
   typedef struct packed {
      logic                valid;
      logic                hit;
      logic                full;
      logic [COV_BITS-1:0] q;
      logic [NUM_BITS-1:0] n;
      logic [PIX_BITS-1:0] dest;
   } div_stage_type;

   // Exact floor(x / 255) for any 16-bit x below 65280 (quotient fits 8 bits)
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return t[15:8];
   endfunction

endpackage

>>> rtl/rrcb_cov_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcb_cov_div
// Pipelined restoring divider: one quotient bit per stage, computes
// coverage = n / den for n below 256 * den.
// ----------------------------------------------------------------------------
module rrcb_cov_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic [rrcb_pkg::DEN_BITS-1:0]      den,
   input  rrcb_pkg::div_stage_type            din,
   output rrcb_pkg::div_stage_type            dout
);

   rrcb_pkg::div_stage_type stg_ff [rrcb_pkg::DIV_STAGES];
   rrcb_pkg::div_stage_type stg_in [rrcb_pkg::DIV_STAGES];

   // Resolve one quotient bit per stage, most significant first
   always_comb begin
      rrcb_pkg::div_stage_type    src;
      logic [rrcb_pkg::NUM_BITS-1:0] dsh;
      int b;
      for (int i = 0; i < rrcb_pkg::DIV_STAGES; i++) begin
         src = (i == 0) ? din : stg_ff[(i == 0) ? 0 : i - 1];
         b   = rrcb_pkg::DIV_STAGES - 1 - i;
         dsh = {{rrcb_pkg::COV_BITS{1'b0}}, den} << b;
         stg_in[i] = src;
         if (src.n >= dsh) begin
            stg_in[i].n    = src.n - dsh;
            stg_in[i].q[b] = 1'b1;
         end
      end
   end

   // Advance all stages together; clear valid bits on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rrcb_pkg::DIV_STAGES; i++) begin
            stg_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         for (int i = 0; i < rrcb_pkg::DIV_STAGES; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   assign dout = stg_ff[rrcb_pkg::DIV_STAGES-1];

endmodule

>>> rtl/rrcb_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrcb_blend
// Scales fill alpha by coverage and blends fill over destination per
// channel with division by 255; alpha of a written result is forced opaque.
// ----------------------------------------------------------------------------
module rrcb_blend (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic [rrcb_pkg::PIX_BITS-1:0]     fill_color,
   input  rrcb_pkg::div_stage_type           din,
   output logic                              out_valid,
   output logic                              out_we,
   output logic [rrcb_pkg::PIX_BITS-1:0]     out_value
);

   logic [7:0] alpha;
   assign alpha = fill_color[31:24];

   // Stage 1: alpha times coverage
   logic        m1_valid_ff, m1_hit_ff, m1_full_ff;
   logic [15:0] m1_prod_ff, m1_prod_in;
   logic [31:0] m1_dest_ff;
   assign m1_prod_in = alpha * din.q;

   // Stage 2: effective alpha and write decision
   logic        m2_valid_ff, m2_we_ff, m2_we_in;
   logic [7:0]  m2_a_ff, m2_a_in;
   logic [31:0] m2_dest_ff;
   assign m2_a_in  = m1_full_ff ? alpha : rrcb_pkg::div255(m1_prod_ff);
   assign m2_we_in = m1_hit_ff && (m2_a_in != 8'd0);

   // Stage 3: per-channel weighted sums
   logic             b1_valid_ff, b1_we_ff;
   logic [2:0][15:0] b1_sum_ff, b1_sum_in;
   always_comb begin
      logic [7:0] inv;
      inv = 8'd255 - m2_a_ff;
      for (int k = 0; k < 3; k++) begin
         b1_sum_in[k] = fill_color[8*k +: 8] * m2_a_ff + m2_dest_ff[8*k +: 8] * inv;
      end
   end

   // Stage 4: divide by 255 and pack the result
   logic        o_valid_ff, o_we_ff;
   logic [31:0] o_value_ff, o_value_in;
   always_comb begin
      o_value_in = '0;
      if (b1_we_ff) begin
         o_value_in[31:24] = rrcb_pkg::ALPHA_OPAQUE;
         for (int k = 0; k < 3; k++) begin
            o_value_in[8*k +: 8] = rrcb_pkg::div255(b1_sum_ff[k]);
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
         b1_valid_ff <= 1'b0;
         o_valid_ff  <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= din.valid;
         m2_valid_ff <= m1_valid_ff;
         b1_valid_ff <= m2_valid_ff;
         o_valid_ff  <= b1_valid_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_hit_ff  <= din.hit;
         m1_full_ff <= din.full;
         m1_prod_ff <= m1_prod_in;
         m1_dest_ff <= din.dest;
         m2_we_ff   <= m2_we_in;
         m2_a_ff    <= m2_a_in;
         m2_dest_ff <= m1_dest_ff;
         b1_we_ff   <= m2_we_ff;
         b1_sum_ff  <= b1_sum_in;
         o_we_ff    <= b1_we_ff;
         o_value_ff <= o_value_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_we    = o_we_ff;
   assign out_value = o_value_ff;

endmodule

>>> rtl/rounded_rect_coverage_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_coverage_blend
// Antialiased rounded-rectangle fill: per-pixel coverage and blend.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one pixel per transaction: coordinates and the current
//          framebuffer ARGB value. rsp_* returns one transaction per pixel:
//          rsp_tuser is the write enable, rsp_tdata the new ARGB value (zero
//          when no write).
//   csr_*  writes rectangle, radius and fill color; the user must do so only
//          while the block is idle, which the block does not enforce. After a
//          write req_tready stays low while the clamped radius, corner centers and
//          squared radii are recomputed.
//   Throughput is one pixel per clock while rsp_tready is high and no CSR
//   write is settling. A pixel passes 4 geometry stages (classify, square,
//   distance compare, numerator), 8 restoring-divider stages for coverage
//   (one quotient bit each) and 4 blend stages (alpha scale, alpha, channel
//   sums, /255).
//   When rsp_tready is low while rsp_tvalid is high, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated.
//   Reset clears all valid bits and the configuration and derived registers;
//   req_tready rises once the settle counter has run down after reset is released.
// ----------------------------------------------------------------------------
module rounded_rect_coverage_blend (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel_x [15:0], pixel_y [31:16], dest_pixel [63:32]
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [rrcb_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   // pixel_value [31:0]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rrcb_pkg::PIX_BITS-1:0]          rsp_tdata,
   // write_enable [0]
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic [rrcb_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rrcb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int PB = rrcb_pkg::POS_BITS;
   localparam int RB = rrcb_pkg::RAD_BITS;
   localparam int CB = rrcb_pkg::COORD_BITS;
   localparam int LB = rrcb_pkg::LEN_BITS;
   localparam int SB = rrcb_pkg::SQ_BITS;
   localparam int DB = rrcb_pkg::DIST_BITS;
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic signed [CB-1:0] left_ff, top_ff;
   logic [LB-1:0]        width_ff, height_ff, radius_ff;
   logic [31:0]          color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         radius_ff <= '0;
         color_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rrcb_pkg::CSR_RECT_LEFT:     left_ff   <= csr_wdata[CB-1:0];
            rrcb_pkg::CSR_RECT_TOP:      top_ff    <= csr_wdata[CB-1:0];
            rrcb_pkg::CSR_RECT_WIDTH:    width_ff  <= csr_wdata[LB-1:0];
            rrcb_pkg::CSR_RECT_HEIGHT:   height_ff <= csr_wdata[LB-1:0];
            rrcb_pkg::CSR_CORNER_RADIUS: radius_ff <= csr_wdata[LB-1:0];
            rrcb_pkg::CSR_FILL_COLOR:    color_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Hold off pixels until derived values have settled
   logic [1:0] settle_ff, settle_in;
   assign settle_in = csr_we ? SETTLE_CYCLES :
                      (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   // ------------------------------------------------------------------
   // Derived geometry, first step: clamped radius and far edges
   // ------------------------------------------------------------------
   logic signed [PB-1:0] left_ext, top_ext;
   logic signed [PB-1:0] right_ff, right_in, bottom_ff, bottom_in;
   logic [RB-1:0]        rad_ff, rad_in;

   assign left_ext  = {{(PB-CB){left_ff[CB-1]}}, left_ff};
   assign top_ext   = {{(PB-CB){top_ff[CB-1]}}, top_ff};
   assign right_in  = left_ext + $signed({{(PB-LB){1'b0}}, width_ff});
   assign bottom_in = top_ext + $signed({{(PB-LB){1'b0}}, height_ff});

   always_comb begin
      logic [LB-1:0] rt;
      rt = radius_ff;
      if (rt > {1'b0, width_ff[LB-1:1]}) begin
         rt = {1'b0, width_ff[LB-1:1]};
      end
      if (rt > {1'b0, height_ff[LB-1:1]}) begin
         rt = {1'b0, height_ff[LB-1:1]};
      end
      rad_in = rt[RB-1:0];
   end

   // Derived geometry, second step: squared radii, divisor, corner centers
   logic [SB-1:0]                    r2o_ff, r2o_in, r2i_ff, r2i_in;
   logic [rrcb_pkg::DEN_BITS-1:0]    den_ff, den_in;
   logic signed [PB-1:0]             lc_ff, lc_in, rc_ff, rc_in;
   logic signed [PB-1:0]             tc_ff, tc_in, bc_ff, bc_in;
   logic [RB-1:0]                    rad_m1;
   logic signed [PB-1:0]             rad_ext;

   assign rad_m1  = (rad_ff == '0) ? '0 : rad_ff - 1'b1;
   assign rad_ext = $signed({{(PB-RB){1'b0}}, rad_ff});
   assign r2o_in  = rad_ff * rad_ff;
   assign r2i_in  = rad_m1 * rad_m1;
   assign den_in  = (rad_ff == '0) ? {{(rrcb_pkg::DEN_BITS-1){1'b0}}, 1'b1}
                                   : {rad_ff, 1'b0} - 1'b1;
   assign lc_in   = left_ext + rad_ext;
   assign rc_in   = right_ff - rad_ext;
   assign tc_in   = top_ext + rad_ext;
   assign bc_in   = bottom_ff - rad_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff    <= '0;
         right_ff  <= '0;
         bottom_ff <= '0;
         r2o_ff    <= '0;
         r2i_ff    <= '0;
         den_ff    <= '0;
         lc_ff     <= '0;
         rc_ff     <= '0;
         tc_ff     <= '0;
         bc_ff     <= '0;
      end else begin
         rad_ff    <= rad_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         r2o_ff    <= r2o_in;
         r2i_ff    <= r2i_in;
         den_ff    <= den_in;
         lc_ff     <= lc_in;
         rc_ff     <= rc_in;
         tc_ff     <= tc_in;
         bc_ff     <= bc_in;
      end
   end

   // ------------------------------------------------------------------
   // Handshake: the whole pipeline moves when the output can drain
   // ------------------------------------------------------------------
   logic adv, accept;
   logic out_valid, out_we;
   logic [31:0] out_value;

   assign adv        = !out_valid || rsp_tready;
   assign req_tready = adv && (settle_ff == 2'd0);
   assign accept     = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // Stage 1: bounds test, corner classification, corner offsets
   // ------------------------------------------------------------------
   logic signed [PB-1:0] px, py, dx_full, dy_full;
   logic                 xl, xr, yt, yb;
   logic                 s1_valid_ff, s1_inside_ff, s1_inside_in;
   logic                 s1_corner_ff, s1_corner_in;
   logic [RB-1:0]        s1_dx_ff, s1_dy_ff;
   logic [31:0]          s1_dest_ff;

   assign px = {{(PB-CB){req_tdata[CB-1]}}, req_tdata[CB-1:0]};
   assign py = {{(PB-CB){req_tdata[2*CB-1]}}, req_tdata[2*CB-1:CB]};
   assign xl = px < lc_ff;
   assign xr = px >= rc_ff;
   assign yt = py < tc_ff;
   assign yb = py >= bc_ff;
   assign s1_inside_in = (px >= left_ext) && (px < right_ff) &&
                         (py >= top_ext) && (py < bottom_ff);
   assign s1_corner_in = (xl || xr) && (yt || yb);
   assign dx_full = xl ? lc_ff - px : px - rc_ff + {{(PB-1){1'b0}}, 1'b1};
   assign dy_full = yt ? tc_ff - py : py - bc_ff + {{(PB-1){1'b0}}, 1'b1};

   // Stage 2: squares of the offsets
   logic          s2_valid_ff, s2_inside_ff, s2_corner_ff;
   logic [SB-1:0] s2_dx2_ff, s2_dy2_ff;
   logic [31:0]   s2_dest_ff;

   // Stage 3: distance against inner and outer circle, coverage margin
   logic          s3_valid_ff, s3_hit_ff, s3_full_ff;
   logic          s3_hit_in, s3_full_in;
   logic [DB-1:0] d2;
   logic [rrcb_pkg::DEN_BITS-1:0] s3_m_ff, s3_m_in;
   logic [31:0]   s3_dest_ff;

   assign d2         = {1'b0, s2_dx2_ff} + {1'b0, s2_dy2_ff};
   assign s3_full_in = !s2_corner_ff || (d2 <= {1'b0, r2i_ff});
   assign s3_hit_in  = s2_inside_ff && (s3_full_in || (d2 <= {1'b0, r2o_ff}));
   assign s3_m_in    = rrcb_pkg::DEN_BITS'({1'b0, r2o_ff} - d2);

   // Stage 4: numerator margin * 255 for the divider
   rrcb_pkg::div_stage_type s4_ff, s4_in;
   always_comb begin
      s4_in.valid = s3_valid_ff;
      s4_in.hit   = s3_hit_ff;
      s4_in.full  = s3_full_ff;
      s4_in.q     = '0;
      s4_in.n     = {s3_m_ff, {rrcb_pkg::COV_BITS{1'b0}}}
                    - {{rrcb_pkg::COV_BITS{1'b0}}, s3_m_ff};
      s4_in.dest  = s3_dest_ff;
   end

   // Valid bits; the divider input register advances here as a whole
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_ff.valid <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_ff       <= s4_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_inside_ff <= s1_inside_in;
         s1_corner_ff <= s1_corner_in;
         s1_dx_ff     <= dx_full[RB-1:0];
         s1_dy_ff     <= dy_full[RB-1:0];
         s1_dest_ff   <= req_tdata[2*CB +: 32];
         s2_inside_ff <= s1_inside_ff;
         s2_corner_ff <= s1_corner_ff;
         s2_dx2_ff    <= s1_dx_ff * s1_dx_ff;
         s2_dy2_ff    <= s1_dy_ff * s1_dy_ff;
         s2_dest_ff   <= s1_dest_ff;
         s3_hit_ff    <= s3_hit_in;
         s3_full_ff   <= s3_full_in;
         s3_m_ff      <= s3_m_in;
         s3_dest_ff   <= s2_dest_ff;
      end
   end

   // ------------------------------------------------------------------
   // Coverage divider and blend
   // ------------------------------------------------------------------
   rrcb_pkg::div_stage_type cov;

   rrcb_cov_div u_cov_div (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .den   (den_ff),
      .din   (s4_ff),
      .dout  (cov)
   );

   rrcb_blend u_blend (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .fill_color (color_ff),
      .din        (cov),
      .out_valid  (out_valid),
      .out_we     (out_we),
      .out_value  (out_value)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tuser  = out_we;
   assign rsp_tdata  = out_value;

endmodule
